>>> sv/ile_pkg.sv
// Shared types and constants of the indexed list engine.
`timescale 1ns / 1ps

package ile_pkg;

    localparam int ILE_DEPTH     = 16;
    localparam int ILE_WORD_BITS = 32;
    localparam int ILE_MODE_BITS = 3;

    typedef enum logic [ILE_MODE_BITS-1:0] {
        MODE_GET     = 3'd0,
        MODE_SET     = 3'd1,
        MODE_PUSH    = 3'd2,
        MODE_POP     = 3'd3,
        MODE_DEQUEUE = 3'd4,
        MODE_INSERT  = 3'd5,
        MODE_REMOVE  = 3'd6,
        MODE_FIND    = 3'd7
    } mode_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan_clr;
        logic scan_step;
        logic find_done;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_find;
        logic scan_hit;
        logic scan_end;
        logic out_free;
    } ctrl_status_t;

endpackage

>>> sv/ile_datapath.sv
// Datapath of the indexed list engine: request latch, shift cells, count, scan and output register.
`timescale 1ns / 1ps

module ile_datapath
    import ile_pkg::*;
#(
    parameter int DEPTH     = ILE_DEPTH,
    parameter int WORD_BITS = ILE_WORD_BITS,
    parameter int IW        = $clog2(DEPTH),
    parameter int CW        = $clog2(DEPTH + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mode_t                req_mode,
    input  logic [IW-1:0]        req_position,
    input  logic [WORD_BITS-1:0] req_word,
    input  ctrl_cmd_t            cmd,
    output ctrl_status_t         status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [WORD_BITS-1:0] out_word,
    output logic                 out_ok,
    output logic [IW-1:0]        out_found_at,
    output logic [CW-1:0]        out_count
);

    mode_t                mode_reg;
    logic [IW-1:0]        pos_reg;
    logic [WORD_BITS-1:0] word_reg;

    logic [WORD_BITS-1:0] cells_reg  [DEPTH];
    logic [WORD_BITS-1:0] cells_next [DEPTH];
    logic [CW-1:0]        used_reg;
    logic [CW-1:0]        used_next;
    logic [CW-1:0]        idx_reg;

    logic                 out_valid_reg;
    logic [WORD_BITS-1:0] out_word_reg;
    logic                 out_ok_reg;
    logic [IW-1:0]        out_at_reg;
    logic [CW-1:0]        out_count_reg;

    logic [CW-1:0]        pos_ext;
    logic [CW-1:0]        used_m1;
    logic                 pos_valid;
    logic                 pos_in_range;
    logic                 not_empty;
    logic                 not_full;
    logic [IW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] rd_word;
    logic                 res_ok;
    logic [WORD_BITS-1:0] res_word;
    logic                 scan_hit;
    logic                 out_free;

    assign pos_ext      = CW'(pos_reg);
    assign used_m1      = used_reg - CW'(1);
    assign pos_valid    = pos_ext < used_reg;
    assign pos_in_range = pos_ext < CW'(DEPTH);
    assign not_empty    = used_reg != '0;
    assign not_full     = used_reg < CW'(DEPTH);
    assign out_free     = !out_valid_reg || out_ready;

    always_comb begin
        case (mode_reg)
            MODE_GET:     rd_addr = pos_reg;
            MODE_POP:     rd_addr = used_m1[IW-1:0];
            MODE_DEQUEUE: rd_addr = '0;
            default:      rd_addr = idx_reg[IW-1:0];
        endcase
    end

    assign rd_word  = cells_reg[rd_addr];
    assign scan_hit = (idx_reg < used_reg) && (rd_word == word_reg);

    always_comb begin
        cells_next = cells_reg;
        used_next  = used_reg;
        res_ok     = 1'b0;
        res_word   = '0;
        case (mode_reg)
            MODE_GET: begin
                if (pos_valid) begin
                    res_ok   = 1'b1;
                    res_word = rd_word;
                end
            end
            MODE_SET: begin
                if (pos_valid) begin
                    res_ok             = 1'b1;
                    cells_next[pos_reg] = word_reg;
                end
            end
            MODE_PUSH: begin
                if (not_full) begin
                    res_ok                       = 1'b1;
                    cells_next[used_reg[IW-1:0]] = word_reg;
                    used_next                    = used_reg + CW'(1);
                end
            end
            MODE_POP: begin
                if (not_empty) begin
                    res_ok    = 1'b1;
                    res_word  = rd_word;
                    used_next = used_m1;
                end
            end
            MODE_DEQUEUE: begin
                if (not_empty) begin
                    res_ok   = 1'b1;
                    res_word = rd_word;
                    for (int k = 0; k < DEPTH - 1; k++) begin
                        if (CW'(k + 1) < used_reg) begin
                            cells_next[k] = cells_reg[k + 1];
                        end
                    end
                    used_next = used_m1;
                end
            end
            MODE_INSERT: begin
                if (pos_valid) begin
                    if (not_full) begin
                        res_ok = 1'b1;
                        for (int k = 1; k < DEPTH; k++) begin
                            if ((CW'(k) > pos_ext) && (CW'(k) <= used_reg)) begin
                                cells_next[k] = cells_reg[k - 1];
                            end
                        end
                        cells_next[pos_reg] = word_reg;
                        used_next           = used_reg + CW'(1);
                    end
                end else if (pos_in_range) begin
                    res_ok              = 1'b1;
                    cells_next[pos_reg] = word_reg;
                    used_next           = pos_ext + CW'(1);
                end
            end
            MODE_REMOVE: begin
                if (pos_valid) begin
                    res_ok = 1'b1;
                    for (int k = 0; k < DEPTH - 1; k++) begin
                        if ((CW'(k) >= pos_ext) && (CW'(k + 1) < used_reg)) begin
                            cells_next[k] = cells_reg[k + 1];
                        end
                    end
                    used_next = used_m1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= req_mode;
            pos_reg  <= req_position;
            word_reg <= req_word;
        end
        if (cmd.exec) begin
            cells_reg <= cells_next;
        end
        if (cmd.exec) begin
            out_word_reg  <= res_word;
            out_ok_reg    <= res_ok;
            out_at_reg    <= '0;
            out_count_reg <= used_next;
        end else if (cmd.find_done) begin
            out_word_reg  <= '0;
            out_ok_reg    <= scan_hit;
            out_at_reg    <= scan_hit ? idx_reg[IW-1:0] : '0;
            out_count_reg <= used_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.exec) begin
                used_reg <= used_next;
            end
            if (cmd.scan_clr) begin
                idx_reg <= '0;
            end else if (cmd.scan_step) begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.exec || cmd.find_done) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.is_find  = mode_reg == MODE_FIND;
    assign status.scan_hit = scan_hit;
    assign status.scan_end = idx_reg == used_reg;
    assign status.out_free = out_free;

    assign out_valid    = out_valid_reg;
    assign out_word     = out_word_reg;
    assign out_ok       = out_ok_reg;
    assign out_found_at = out_at_reg;
    assign out_count    = out_count_reg;

endmodule

>>> sv/ile_controller.sv
// Controller state machine of the indexed list engine.
`timescale 1ns / 1ps

module ile_controller
    import ile_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.is_find) begin
                    cmd.scan_clr = 1'b1;
                    state_next   = ST_SCAN;
                end else if (status.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (status.scan_hit || status.scan_end) begin
                    if (status.out_free) begin
                        cmd.find_done = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = state_reg == ST_IDLE;

endmodule

>>> sv/indexed_list_engine.sv
// Top level of the indexed list engine: stream ports, controller and datapath.
//
// The engine keeps an ordered list of up to DEPTH words with a count of valid
// entries. Each transaction on the s_axis channel carries one request and
// produces exactly one transaction on the m_axis channel.
// The request kind (get, set, push, pop, dequeue, insert, remove, find) comes
// in s_axis_tuser; position and word come in s_axis_tdata.
// The result word, found index and entry count go out in m_axis_tdata, and
// the success flag in m_axis_tuser.
// One request is in work at a time. A request other than find is latched, then
// executed once the output register is free, which writes its result there and
// frees the input. A find walks the list one entry per cycle through the single
// read port of the cells; it ends on a hit or at the end of the list, and once
// the output register is free its result is written there and the input frees.
// The next request is accepted while the previous result still waits in the
// output register. If the receiver stalls, the finished work waits until the
// output register frees, and at most one further request is accepted.
// Reset empties the list and drops any pending result; the cell contents
// are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module indexed_list_engine
    import ile_pkg::*;
#(
    parameter int DEPTH     = ILE_DEPTH,
    parameter int WORD_BITS = ILE_WORD_BITS
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         s_axis_tvalid,
    output logic                                         s_axis_tready,
    // Fields from bit 0: position, word_in.
    input  logic [((($clog2(DEPTH) + WORD_BITS) + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // Fields from bit 0: mode.
    input  logic [ILE_MODE_BITS-1:0]                     s_axis_tuser,
    output logic                                         m_axis_tvalid,
    input  logic                                         m_axis_tready,
    // Fields from bit 0: word_out, found_at, entry_count.
    output logic [(((WORD_BITS + $clog2(DEPTH) + $clog2(DEPTH + 1)) + 7) / 8) * 8 - 1:0]
                                                         m_axis_tdata,
    // Fields from bit 0: ok.
    output logic                                         m_axis_tuser
);

    localparam int IW          = $clog2(DEPTH);
    localparam int CW          = $clog2(DEPTH + 1);
    localparam int OUT_BITS    = WORD_BITS + IW + CW;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    ctrl_cmd_t            cmd;
    ctrl_status_t         status;
    logic [WORD_BITS-1:0] out_word;
    logic                 out_ok;
    logic [IW-1:0]        out_found_at;
    logic [CW-1:0]        out_count;

    ile_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ile_datapath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .IW        (IW),
        .CW        (CW)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req_mode     (mode_t'(s_axis_tuser)),
        .req_position (s_axis_tdata[IW-1:0]),
        .req_word     (s_axis_tdata[IW+WORD_BITS-1:IW]),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_word     (out_word),
        .out_ok       (out_ok),
        .out_found_at (out_found_at),
        .out_count    (out_count)
    );

    assign m_axis_tdata = OUT_TDATA_W'({out_count, out_found_at, out_word});
    assign m_axis_tuser = out_ok;

endmodule

>>> sv/ile_checker.sv
// Port-level assertions of the indexed list engine and their binding to the top level.
`timescale 1ns / 1ps

module ile_checker
    import ile_pkg::*;
#(
    parameter int DEPTH     = ILE_DEPTH,
    parameter int WORD_BITS = ILE_WORD_BITS
) (
    input logic                                         aclk,
    input logic                                         aresetn,
    input logic                                         s_axis_tvalid,
    input logic                                         s_axis_tready,
    input logic [((($clog2(DEPTH) + WORD_BITS) + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input logic [ILE_MODE_BITS-1:0]                     s_axis_tuser,
    input logic                                         m_axis_tvalid,
    input logic                                         m_axis_tready,
    input logic [(((WORD_BITS + $clog2(DEPTH) + $clog2(DEPTH + 1)) + 7) / 8) * 8 - 1:0]
                                                        m_axis_tdata,
    input logic                                         m_axis_tuser
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WORD_BITS-1:0] word_out;
    logic [IW-1:0]        found_at;
    logic [CW-1:0]        entry_count;

    assign word_out    = m_axis_tdata[WORD_BITS-1:0];
    assign found_at    = m_axis_tdata[WORD_BITS+IW-1:WORD_BITS];
    assign entry_count = m_axis_tdata[WORD_BITS+IW+CW-1:WORD_BITS+IW];

    // A stalled result keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // A failed request reports no data and no index.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> word_out == '0 && found_at == '0)
        else $error("failed request carries data");

    // The reported count never exceeds the list capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> entry_count <= CW'(DEPTH))
        else $error("entry count beyond capacity");

    // Requests are taken one at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted back to back");

    // No result is offered in the cycle after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind indexed_list_engine ile_checker #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
) u_ile_checker (.*);

>>> tb/sv/indexed_list_engine_tb.sv
// Self-checking testbench of the indexed list engine, driven by directed and random requests.
`timescale 1ns / 1ps

module indexed_list_engine_tb;
    import ile_pkg::*;

    localparam int POS_BITS   = $clog2(ILE_DEPTH);
    localparam int COUNT_BITS = $clog2(ILE_DEPTH + 1);
    localparam int S_DATA_W   = ((POS_BITS + ILE_WORD_BITS + 7) / 8) * 8;
    localparam int M_DATA_W   = ((ILE_WORD_BITS + POS_BITS + COUNT_BITS + 7) / 8) * 8;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct {
        mode_t                    mode;
        logic [POS_BITS-1:0]      pos;
        logic [ILE_WORD_BITS-1:0] word;
    } list_request_t;

    typedef struct {
        logic [ILE_WORD_BITS-1:0] word;
        logic                     ok;
        logic [POS_BITS-1:0]      at;
        logic [COUNT_BITS-1:0]    count;
    } list_result_t;

    typedef struct {
        list_request_t req;
        bit            typed;
        list_result_t  want;
    } directed_row_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [S_DATA_W-1:0]      s_axis_tdata = '0;
    logic [ILE_MODE_BITS-1:0] s_axis_tuser = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]      m_axis_tdata;
    logic                     m_axis_tuser;

    logic [ILE_WORD_BITS-1:0] list_words [ILE_DEPTH];
    bit                       list_known [ILE_DEPTH];
    int                       list_count;

    list_result_t  pending_results[$];
    directed_row_t directed_rows[$];
    int            mismatch_count = 0;
    int            result_index = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            hold_requests = 0;
    int            hold_served = 0;
    int            stall_left = 0;

    indexed_list_engine dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic list_result_t apply_list_request(list_request_t r);
        list_result_t res;
        int           p;
        int           k;
        res.word = '0;
        res.ok = 1'b0;
        res.at = '0;
        p = int'(r.pos);
        case (r.mode)
            MODE_GET: begin
                if (p < list_count) begin
                    res.word = list_words[p];
                    res.ok = 1'b1;
                end
            end
            MODE_SET: begin
                if (p < list_count) begin
                    list_words[p] = r.word;
                    list_known[p] = 1'b1;
                    res.ok = 1'b1;
                end
            end
            MODE_PUSH: begin
                if (list_count < ILE_DEPTH) begin
                    list_words[list_count] = r.word;
                    list_known[list_count] = 1'b1;
                    list_count++;
                    res.ok = 1'b1;
                end
            end
            MODE_POP: begin
                if (list_count > 0) begin
                    res.word = list_words[list_count - 1];
                    list_count--;
                    res.ok = 1'b1;
                end
            end
            MODE_DEQUEUE: begin
                if (list_count > 0) begin
                    res.word = list_words[0];
                    for (k = 0; k + 1 < list_count; k++) begin
                        list_words[k] = list_words[k + 1];
                        list_known[k] = list_known[k + 1];
                    end
                    list_count--;
                    res.ok = 1'b1;
                end
            end
            MODE_INSERT: begin
                if (p < list_count) begin
                    if (list_count < ILE_DEPTH) begin
                        for (k = list_count; k > p; k--) begin
                            list_words[k] = list_words[k - 1];
                            list_known[k] = list_known[k - 1];
                        end
                        list_words[p] = r.word;
                        list_known[p] = 1'b1;
                        list_count++;
                        res.ok = 1'b1;
                    end
                end else begin
                    list_words[p] = r.word;
                    list_known[p] = 1'b1;
                    list_count = p + 1;
                    res.ok = 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (p < list_count) begin
                    for (k = p; k + 1 < list_count; k++) begin
                        list_words[k] = list_words[k + 1];
                        list_known[k] = list_known[k + 1];
                    end
                    list_count--;
                    res.ok = 1'b1;
                end
            end
            default: begin
                for (k = 0; k < list_count; k++) begin
                    if (!res.ok && list_words[k] == r.word) begin
                        res.ok = 1'b1;
                        res.at = k[POS_BITS-1:0];
                    end
                end
            end
        endcase
        res.count = list_count[COUNT_BITS-1:0];
        return res;
    endfunction

    // A request that would read a cell never written becomes a set of that cell.
    function automatic list_request_t avoid_unwritten_read(list_request_t r);
        list_request_t safe;
        int            k;
        int            gap;
        safe = r;
        gap = -1;
        for (k = list_count - 1; k >= 0; k--) begin
            if (!list_known[k]) gap = k;
        end
        case (r.mode)
            MODE_GET: begin
                if (int'(r.pos) < list_count && !list_known[r.pos]) safe.mode = MODE_SET;
            end
            MODE_POP: begin
                if (list_count > 0 && !list_known[list_count - 1]) begin
                    safe.mode = MODE_SET;
                    safe.pos = POS_BITS'(list_count - 1);
                end
            end
            MODE_DEQUEUE: begin
                if (list_count > 0 && !list_known[0]) begin
                    safe.mode = MODE_SET;
                    safe.pos = '0;
                end
            end
            MODE_FIND: begin
                if (gap >= 0) begin
                    safe.mode = MODE_SET;
                    safe.pos = POS_BITS'(gap);
                end
            end
            default: ;
        endcase
        return safe;
    endfunction

    function automatic list_request_t random_request(bit growing);
        list_request_t r;
        int            pick;
        int            idx;
        pick = $urandom_range(0, 99);
        if (growing) begin
            if (pick < 30)      r.mode = MODE_PUSH;
            else if (pick < 45) r.mode = MODE_INSERT;
            else if (pick < 55) r.mode = MODE_SET;
            else if (pick < 65) r.mode = MODE_GET;
            else if (pick < 80) r.mode = MODE_FIND;
            else                r.mode = mode_t'($urandom_range(0, 7));
        end else begin
            if (pick < 20)      r.mode = MODE_POP;
            else if (pick < 35) r.mode = MODE_DEQUEUE;
            else if (pick < 50) r.mode = MODE_REMOVE;
            else if (pick < 60) r.mode = MODE_GET;
            else if (pick < 70) r.mode = MODE_SET;
            else if (pick < 85) r.mode = MODE_FIND;
            else                r.mode = mode_t'($urandom_range(0, 7));
        end
        if ($urandom_range(0, 3) == 0 || list_count == 0)
            r.pos = POS_BITS'($urandom_range(0, ILE_DEPTH - 1));
        else
            r.pos = POS_BITS'($urandom_range(0, (list_count < ILE_DEPTH) ? list_count
                                                                         : ILE_DEPTH - 1));
        if ($urandom_range(0, 2) == 0)
            r.word = ILE_WORD_BITS'($urandom_range(0, 3));
        else
            r.word = $urandom;
        if (r.mode == MODE_FIND && list_count > 0 && $urandom_range(0, 1) == 1) begin
            idx = $urandom_range(0, list_count - 1);
            if (list_known[idx]) r.word = list_words[idx];
        end
        return r;
    endfunction

    task automatic add_row(input mode_t mode, input int pos, input logic [31:0] word,
                           input bit typed, input logic [31:0] w_word, input bit w_ok,
                           input int w_at, input int w_count);
        directed_row_t row;
        row.req.mode = mode;
        row.req.pos = POS_BITS'(pos);
        row.req.word = word;
        row.typed = typed;
        row.want.word = w_word;
        row.want.ok = w_ok;
        row.want.at = POS_BITS'(w_at);
        row.want.count = COUNT_BITS'(w_count);
        directed_rows.push_back(row);
    endtask

    task automatic send_request(input list_request_t r, input bit typed,
                                input list_result_t want);
        logic [S_DATA_W-1:0] packed_data;
        list_result_t        predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        packed_data = '0;
        packed_data[POS_BITS-1:0] = r.pos;
        packed_data[POS_BITS +: ILE_WORD_BITS] = r.word;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= packed_data;
        s_axis_tuser <= r.mode;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predicted = apply_list_request(r);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch in result %0d, %s: got %0h, expected %0h",
                 result_index, field, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction", 64'(m_axis_tdata), '0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[ILE_WORD_BITS-1:0] !== want.word)
                    report_mismatch("word_out", 64'(m_axis_tdata[ILE_WORD_BITS-1:0]),
                                    64'(want.word));
                if (m_axis_tuser !== want.ok)
                    report_mismatch("ok", 64'(m_axis_tuser), 64'(want.ok));
                if (m_axis_tdata[ILE_WORD_BITS +: POS_BITS] !== want.at)
                    report_mismatch("found_at", 64'(m_axis_tdata[ILE_WORD_BITS +: POS_BITS]),
                                    64'(want.at));
                if (m_axis_tdata[ILE_WORD_BITS + POS_BITS +: COUNT_BITS] !== want.count)
                    report_mismatch("entry_count",
                                    64'(m_axis_tdata[ILE_WORD_BITS + POS_BITS +: COUNT_BITS]),
                                    64'(want.count));
            end
            result_index++;
        end
        if (hold_served != hold_requests) begin
            stall_left = HOLD_OFF_CYCLES;
            hold_served++;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        list_request_t r;
        list_result_t  unused;
        int            phase;
        int            i;
        int            random_items [3];
        random_items[0] = 300;
        random_items[1] = 300;
        random_items[2] = 250;
        unused.word = '0;
        unused.ok = 1'b0;
        unused.at = '0;
        unused.count = '0;
        for (i = 0; i < ILE_DEPTH; i++) begin
            list_words[i] = '0;
            list_known[i] = 1'b0;
        end
        list_count = 0;

        add_row(MODE_GET,     0, 32'h0,        1, 32'h0,        0, 0, 0);
        add_row(MODE_POP,     0, 32'h0,        1, 32'h0,        0, 0, 0);
        add_row(MODE_DEQUEUE, 0, 32'h0,        1, 32'h0,        0, 0, 0);
        add_row(MODE_REMOVE,  0, 32'h0,        1, 32'h0,        0, 0, 0);
        add_row(MODE_SET,     0, 32'hDEADBEEF, 1, 32'h0,        0, 0, 0);
        add_row(MODE_FIND,    0, 32'h0,        1, 32'h0,        0, 0, 0);
        add_row(MODE_PUSH,    0, 32'hFFFFFFFF, 1, 32'h0,        1, 0, 1);
        add_row(MODE_PUSH,    0, 32'h0,        1, 32'h0,        1, 0, 2);
        add_row(MODE_GET,     0, 32'h0,        1, 32'hFFFFFFFF, 1, 0, 2);
        add_row(MODE_GET,     1, 32'h0,        1, 32'h0,        1, 0, 2);
        add_row(MODE_GET,     2, 32'h0,        1, 32'h0,        0, 0, 2);
        add_row(MODE_FIND,    0, 32'h0,        1, 32'h0,        1, 1, 2);
        add_row(MODE_FIND,    0, 32'h1,        1, 32'h0,        0, 0, 2);
        add_row(MODE_INSERT,  1, 32'h5,        1, 32'h0,        1, 0, 3);
        add_row(MODE_FIND,    0, 32'h0,        1, 32'h0,        1, 2, 3);
        add_row(MODE_REMOVE,  0, 32'h0,        1, 32'h0,        1, 0, 2);
        add_row(MODE_SET,     1, 32'hFFFFFFFF, 1, 32'h0,        1, 0, 2);
        add_row(MODE_INSERT, 15, 32'hA5A5A5A5, 1, 32'h0,        1, 0, 16);
        add_row(MODE_PUSH,    0, 32'h1,        1, 32'h0,        0, 0, 16);
        add_row(MODE_INSERT,  0, 32'h1,        1, 32'h0,        0, 0, 16);
        add_row(MODE_GET,    15, 32'h0,        1, 32'hA5A5A5A5, 1, 0, 16);
        add_row(MODE_POP,     0, 32'h0,        1, 32'hA5A5A5A5, 1, 0, 15);
        add_row(MODE_DEQUEUE, 0, 32'h0,        1, 32'h5,        1, 0, 14);
        add_row(MODE_SET,     1, 32'h12345678, 1, 32'h0,        1, 0, 14);
        add_row(MODE_GET,     1, 32'h0,        0, 32'h0,        0, 0, 0);
        add_row(MODE_REMOVE, 13, 32'h0,        1, 32'h0,        1, 0, 13);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 31;
        recv_idle_pct = 62;
        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        wait_for_results();

        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 62 : 0;
            recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 31 : 0;
            if (phase == 0) hold_requests++;
            for (i = 0; i < random_items[phase]; i++) begin
                r = avoid_unwritten_read(random_request(((i / 40) % 2) == 0));
                send_request(r, 1'b0, unused);
            end
            wait_for_results();
        end

        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> indexed_list_engine.f
sv/ile_pkg.sv
sv/ile_datapath.sv
sv/ile_controller.sv
sv/indexed_list_engine.sv
sv/ile_checker.sv
tb/sv/indexed_list_engine_tb.sv
